[hdl/kcl_pkg.sv]
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants for the keypad code lock: key codes, lock
// modes, event codes and the result record.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int KEY_W   = 4;
    localparam int EVENT_W = 4;
    localparam int DIGITS_W = 3;
    localparam int CFG_W   = 16;

    // key codes
    localparam logic [KEY_W-1:0] KEY_D0   = 4'd0;
    localparam logic [KEY_W-1:0] KEY_D9   = 4'd9;
    localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

    // factory code after reset, first key in the top nibble
    localparam logic [CFG_W-1:0] INIT_CODE_RST = 16'h1234;

    typedef enum logic [1:0] {
        MODE_ACCESS = 2'd0,
        MODE_VERIFY = 2'd1,
        MODE_NEW    = 2'd2
    } lock_mode_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 4'd0,
        EV_GRANTED = 4'd1,
        EV_DENIED  = 4'd2,
        EV_CHANGE  = 4'd3,
        EV_CANCEL  = 4'd4,
        EV_OLD_OK  = 4'd5,
        EV_OLD_BAD = 4'd6,
        EV_UPDATED = 4'd7,
        EV_CLEARED = 4'd8
    } lock_event_t;

    typedef struct packed {
        lock_event_t         event_res;
        logic [DIGITS_W-1:0] digits_entered;
        lock_mode_t          mode;
    } lock_result_t;

endpackage

[hdl/kcl_core.sv]
// ----------------------------------------------------------------------------
// kcl_core
// Lock state: entry shift buffer, digit count, mode machine and stored code.
// Gives the result of the key on its input in the same cycle and updates
// the state when the key is taken.
// ----------------------------------------------------------------------------
module kcl_core #(
    parameter int CODE_DIGITS = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       take,
    input  logic [kcl_pkg::KEY_W-1:0]  key_code,
    input  logic                       cfg_we,
    input  logic [kcl_pkg::CFG_W-1:0]  cfg_data,
    output kcl_pkg::lock_result_t      result
);
    import kcl_pkg::*;

    localparam int CODE_W = 4 * CODE_DIGITS;
    localparam int CNT_W  = $clog2(CODE_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_DIGITS - 1);

    logic [CODE_W-1:0] buf_reg, buf_next, buf_shift;
    logic [CODE_W-1:0] code_reg, code_next, cfg_code, rst_code;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W+DIGITS_W-1:0] cnt_ext;
    logic [CODE_W+CFG_W-1:0]   cfg_ext, rst_ext;
    lock_mode_t  mode_reg, mode_next;
    lock_event_t ev;
    logic is_digit, is_star, is_hash, full, match;

    // short factory code is zero filled above, long one keeps its low digits
    assign cfg_ext  = (CODE_W + CFG_W)'(cfg_data);
    assign rst_ext  = (CODE_W + CFG_W)'(INIT_CODE_RST);
    assign cfg_code = cfg_ext[CODE_W-1:0];
    assign rst_code = rst_ext[CODE_W-1:0];

    always_comb begin
        is_digit  = key_code inside {[KEY_D0:KEY_D9]};
        is_star   = (key_code == KEY_STAR);
        is_hash   = (key_code == KEY_HASH);
        full      = (cnt_reg == CNT_LAST);
        buf_shift = (buf_reg << 4) | CODE_W'(key_code);
        match     = (buf_shift == code_reg);
    end

    // mode machine
    always_comb begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_ACCESS: begin
                if (is_hash && cnt_reg == '0) begin
                    mode_next = MODE_VERIFY;
                end
            end
            MODE_VERIFY: begin
                if (is_hash) begin
                    mode_next = MODE_ACCESS;
                end else if (is_digit && full) begin
                    mode_next = match ? MODE_NEW : MODE_ACCESS;
                end
            end
            MODE_NEW: begin
                if (is_hash || (is_digit && full)) begin
                    mode_next = MODE_ACCESS;
                end
            end
            default: mode_next = MODE_ACCESS;
        endcase
    end

    // event, entry buffer and code updates
    always_comb begin
        ev        = EV_NONE;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        code_next = code_reg;
        if (is_hash && mode_reg == MODE_ACCESS && cnt_reg == '0) begin
            ev       = EV_CHANGE;
            cnt_next = '0;
        end else if (is_hash && mode_reg != MODE_ACCESS) begin
            ev       = EV_CANCEL;
            cnt_next = '0;
        end else if (is_star) begin
            ev       = EV_CLEARED;
            cnt_next = '0;
        end else if (is_digit) begin
            buf_next = buf_shift;
            if (full) begin
                cnt_next = '0;
                case (mode_reg)
                    MODE_ACCESS: ev = match ? EV_GRANTED : EV_DENIED;
                    MODE_VERIFY: ev = match ? EV_OLD_OK : EV_OLD_BAD;
                    MODE_NEW: begin
                        ev        = EV_UPDATED;
                        code_next = buf_shift;
                    end
                    default: ev = EV_NONE;
                endcase
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    assign cnt_ext = (CNT_W + DIGITS_W)'(cnt_next);

    always_comb begin
        result.event_res      = ev;
        result.digits_entered = cnt_ext[DIGITS_W-1:0];
        result.mode           = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ACCESS;
            cnt_reg  <= '0;
            code_reg <= rst_code;
        end else begin
            if (take) begin
                mode_reg <= mode_next;
                cnt_reg  <= cnt_next;
            end
            if (cfg_we) begin
                code_reg <= cfg_code;
            end else if (take) begin
                code_reg <= code_next;
            end
        end
    end

    // only digits keyed since the last clear are ever compared
    always_ff @(posedge aclk) begin
        if (take) begin
            buf_reg <= buf_next;
        end
    end

endmodule

[hdl/keypad_code_lock.sv]
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad combination lock with code change, one decoded key per request.
// ----------------------------------------------------------------------------
// Each taken key request yields exactly one result request. Keys are handled
// at one per clock while s_ready is high: the whole decision (digit shift,
// parallel compare of all code digits against the stored code, mode update)
// sits between the key accept and the result register. A two-entry result
// buffer (output register plus skid register) keeps taking keys while a
// result waits; s_ready drops only when both entries are full. The code
// register port is always ready and loads the stored code directly; write
// it only while no key is in flight.
module keypad_code_lock #(
    parameter int CODE_DIGITS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // key requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kcl_pkg::KEY_W-1:0]     s_key_code,
    // result requests
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kcl_pkg::EVENT_W-1:0]   m_event_res,
    output logic [kcl_pkg::DIGITS_W-1:0]  m_digits_entered,
    output logic [1:0]                    m_mode,
    // factory code writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kcl_pkg::CFG_W-1:0]     cfg_data
);
    import kcl_pkg::*;

    logic take, pop;
    lock_result_t new_res;
    lock_result_t out_reg, out_next, skid_reg, skid_next;
    logic out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    assign s_ready   = !skid_valid_reg;
    assign take      = s_valid && s_ready;
    assign pop       = out_valid_reg && m_ready;
    assign cfg_ready = 1'b1;

    kcl_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .key_code (s_key_code),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .result   (new_res)
    );

    // result buffer: skid entry always drains into the output register first
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = take;
                skid_next       = new_res;
            end else begin
                out_next       = new_res;
                out_valid_next = take;
            end
        end else if (take) begin
            skid_next       = new_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_event_res      = out_reg.event_res;
    assign m_digits_entered = out_reg.digits_entered;
    assign m_mode           = out_reg.mode;

endmodule

[hdl/kcl_checker.sv]
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level checks for the keypad code lock, bound to the top level.
// ----------------------------------------------------------------------------
module kcl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [kcl_pkg::EVENT_W-1:0]   m_event_res,
    input logic [kcl_pkg::DIGITS_W-1:0]  m_digits_entered,
    input logic [1:0]                    m_mode
);
    import kcl_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res)
            && $stable(m_digits_entered) && $stable(m_mode))
        else $error("result changed while stalled");

    // a full entry, other than an accepted old code, leaves the buffer empty and the lock in access mode
    a_eval_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_GRANTED || m_event_res == EV_DENIED
            || m_event_res == EV_OLD_BAD || m_event_res == EV_UPDATED)
        |-> m_digits_entered == '0 && m_mode == MODE_ACCESS)
        else $error("evaluation left entry or mode wrong");

    a_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_CHANGE
        |-> m_digits_entered == '0 && m_mode == MODE_VERIFY)
        else $error("change start without verify mode");

    a_old_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_OLD_OK
        |-> m_digits_entered == '0 && m_mode == MODE_NEW)
        else $error("old code accepted without new-code mode");

    a_cancel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_CANCEL
        |-> m_digits_entered == '0 && m_mode == MODE_ACCESS)
        else $error("cancel did not return to access mode");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_event_res      (m_event_res),
    .m_digits_entered (m_digits_entered),
    .m_mode           (m_mode)
);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad code lock. Keys go in over a
// valid/ready request channel; an in-bench model of the lock predicts
// event, digit count and mode for every taken key. Results are checked
// in order. Directed tests cover ignored keys, access, code change and
// code register writes. Random traffic then runs under three idle and
// stall settings.
// ----------------------------------------------------------------------------
module tb_top;
    import kcl_pkg::*;

    localparam int CODE_DIGITS   = 4;
    localparam int CODE_W        = 4 * CODE_DIGITS;
    localparam int STALL_LIMIT   = 2000;  // cycles with no request moving on any channel
    localparam int SETTLE_CYCLES = 4;     // quiet cycles after the last result comes back

    // keys outside the decoded set, answered with no event by the lock
    localparam logic [KEY_W-1:0] KEY_IGNORED_LO = 4'd12;
    localparam logic [KEY_W-1:0] KEY_IGNORED_HI = 4'd15;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // key requests
    logic             s_valid    = 1'b0;
    logic             s_ready;
    logic [KEY_W-1:0] s_key_code = '0;

    // result requests
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [EVENT_W-1:0]  m_event_res;
    logic [DIGITS_W-1:0] m_digits_entered;
    logic [1:0]          m_mode;

    // code register writes
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    always #5 aclk = ~aclk;

    keypad_code_lock #(
        .CODE_DIGITS(CODE_DIGITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_key_code      (s_key_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_digits_entered(m_digits_entered),
        .m_mode          (m_mode),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // lock model state, updated as each key is taken
    logic [CODE_W-1:0] model_entry = '0;
    int                model_count = 0;
    lock_mode_t        model_mode  = MODE_ACCESS;
    logic [CODE_W-1:0] model_code  = CODE_W'(INIT_CODE_RST);

    // predicted results, oldest first
    lock_result_t pending_results[$];

    int send_idle_pct = 0;   // chance per cycle that the key side holds off
    int recv_idle_pct = 0;   // chance per cycle that the result side stalls
    int keys_counted  = 0;   // decoded keys taken: digits, star and hash
    int error_count   = 0;
    int stall_cycles  = 0;

    function automatic void clear_entry();
        model_entry = '0;
        model_count = 0;
    endfunction

    // next state and result of the lock for one key
    function automatic lock_result_t lock_predict(input logic [KEY_W-1:0] key);
        lock_result_t res;
        logic         match;
        res.event_res = EV_NONE;
        if (key == KEY_HASH && model_mode == MODE_ACCESS && model_count == 0) begin
            // hash on an empty buffer in access mode opens a code change
            model_mode = MODE_VERIFY;
            clear_entry();
            res.event_res = EV_CHANGE;
        end else if (key == KEY_HASH && model_mode != MODE_ACCESS) begin
            // hash anywhere in a code change backs out of it
            model_mode = MODE_ACCESS;
            clear_entry();
            res.event_res = EV_CANCEL;
        end else if (key == KEY_STAR) begin
            clear_entry();
            res.event_res = EV_CLEARED;
        end else if (key <= KEY_D9 && model_count < CODE_DIGITS) begin
            model_entry = CODE_W'({model_entry, key});
            model_count++;
            if (model_count == CODE_DIGITS) begin
                match = (model_entry == model_code);
                case (model_mode)
                    MODE_ACCESS: begin
                        if (match) res.event_res = EV_GRANTED;
                        else       res.event_res = EV_DENIED;
                    end
                    MODE_VERIFY: begin
                        if (match) begin
                            res.event_res = EV_OLD_OK;
                            model_mode    = MODE_NEW;
                        end else begin
                            res.event_res = EV_OLD_BAD;
                            model_mode    = MODE_ACCESS;
                        end
                    end
                    default: begin
                        model_code    = model_entry;
                        res.event_res = EV_UPDATED;
                        model_mode    = MODE_ACCESS;
                    end
                endcase
                clear_entry();
            end
        end
        // hash on a partial entry and keys above hash fall through as no event
        res.digits_entered = DIGITS_W'(model_count);
        res.mode           = model_mode;
        return res;
    endfunction

    // one key request; valid stays up from one key to the next unless a gap is drawn
    task automatic send_key(input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_key_code <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(lock_predict(key));
        if (key <= KEY_HASH) keys_counted++;
    endtask

    // four bcd digits, first key in the top nibble
    task automatic send_code(input logic [CODE_W-1:0] code);
        for (int i = 0; i < CODE_DIGITS; i++) send_key(code[CODE_W-1-4*i -: 4]);
    endtask

    // a code attempt that mostly follows the stored code
    task automatic send_attempt(input int hit_pct);
        logic [KEY_W-1:0] digit;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            digit = model_code[CODE_W-1-4*i -: 4];
            if (digit > KEY_D9 || $urandom_range(99) >= hit_pct)
                digit = KEY_W'($urandom_range(9));
            send_key(digit);
        end
    endtask

    task automatic send_digits(input int count);
        repeat (count) send_key(KEY_W'($urandom_range(9)));
    endtask

    // drop valid, let every result come back, then SETTLE_CYCLES quiet cycles
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // factory code write, only with the lock idle
    task automatic write_code(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        model_code  = CODE_W'(value);
    endtask

    function automatic logic [CFG_W-1:0] random_code();
        logic [CFG_W-1:0] code;
        code = CFG_W'($urandom);
        // mostly bcd so that random attempts can hit it
        if ($urandom_range(3) != 0)
            for (int i = 0; i < CFG_W / 4; i++) code[4*i +: 4] = 4'($urandom_range(9));
        return code;
    endfunction

    // keys above hash, then a hash on a partial entry, then star
    task automatic test_ignored_keys();
        send_key(KEY_IGNORED_LO);
        send_key(KEY_IGNORED_HI);
        send_key(4'd7);
        send_key(KEY_HASH);
        send_key(KEY_STAR);
    endtask

    // grant on the reset code, deny on the extremes of the digit range
    task automatic test_access();
        send_code(16'h1234);
        send_code(16'h0990);
    endtask

    // change start, cancel, bad old code, good old code, new code stored
    task automatic test_code_change();
        send_key(KEY_HASH);
        send_key(KEY_HASH);
        send_key(KEY_HASH);
        send_code(16'h5234);
        send_key(KEY_HASH);
        send_code(16'h1234);
        send_code(16'h9009);
    endtask

    // register extremes, a non-bcd code, and writes during entry or a change
    task automatic test_code_register();
        write_code(16'h0000);
        send_code(16'h0000);
        write_code(16'hFFFF);
        send_code(16'h9999);
        // partial entry survives a write
        send_key(4'd1);
        send_key(4'd2);
        write_code(16'h1299);
        send_key(4'd9);
        send_key(4'd9);
        // verify mode survives a write
        send_key(KEY_HASH);
        write_code(16'h9876);
        send_code(16'h9876);
        send_key(KEY_HASH);
    endtask

    // random key sequences, mostly well formed, under one idle setting
    task automatic test_random_traffic(input int item_count, input int send_pct,
                                       input int recv_pct);
        int start;
        int pick;
        write_code(random_code());
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = keys_counted;
        while (keys_counted - start < item_count) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_attempt(75);
            end else if (pick < 70) begin
                // full code change, sometimes backed out at the new code
                send_key(KEY_HASH);
                send_attempt(80);
                if (model_mode == MODE_NEW) begin
                    if ($urandom_range(9) == 0) send_key(KEY_HASH);
                    else                        send_digits(CODE_DIGITS);
                end
            end else if (pick < 82) begin
                // partial entry followed by star, which clears it, or by hash
                send_digits($urandom_range(1, CODE_DIGITS - 1));
                if ($urandom_range(1) == 0) send_key(KEY_STAR);
                else                        send_key(KEY_HASH);
            end else begin
                repeat ($urandom_range(1, 3)) send_key(KEY_W'($urandom_range(15)));
            end
        end
    endtask

    // result side: random stalls, in-order check against the model
    always @(posedge aclk) begin
        lock_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: event_res %0d", m_event_res);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_event_res !== want.event_res) begin
                    $error("event_res mismatch: expected %0d, actual %0d",
                           want.event_res, m_event_res);
                    error_count++;
                end
                if (m_digits_entered !== want.digits_entered) begin
                    $error("digits_entered mismatch: expected %0d, actual %0d",
                           want.digits_entered, m_digits_entered);
                    error_count++;
                end
                if (m_mode !== want.mode) begin
                    $error("mode mismatch: expected %0d, actual %0d", want.mode, m_mode);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles where no request moves
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ignored_keys();
        test_access();
        test_code_change();
        test_code_register();

        // sender idles lightly, receiver stalls heavily, then swapped, then flat out
        test_random_traffic(165, 6, 68);
        test_random_traffic(165, 68, 6);
        test_random_traffic(165, 0, 0);

        wait_idle();
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/kcl_pkg.sv
hdl/kcl_core.sv
hdl/keypad_code_lock.sv
hdl/kcl_checker.sv
tb/sv/tb_top.sv
